@@ hw/rtl/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// shared types and constants of the led matrix grayscale scanner
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int PLANES          = 3;

  localparam int KIND_W      = 3;
  localparam int ROW_W       = 4;
  localparam int COLUMN_W    = 6;
  localparam int LEVEL_W     = 8;
  localparam int CELL_W      = 2;
  localparam int ROW_SEL_W   = 16;
  localparam int COL_BITS_W  = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int TICK_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int ROWS_REG_W  = 5;
  localparam int COLS_REG_W  = 7;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RENDER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE2 = 3'd4;

  localparam logic [ROWS_REG_W-1:0] RST_ROWS   = 5'd16;
  localparam logic [COLS_REG_W-1:0] RST_COLS   = 7'd64;
  localparam logic [TICK_W-1:0]     RST_PLANE0 = 8'd1;
  localparam logic [TICK_W-1:0]     RST_PLANE1 = 8'd4;
  localparam logic [TICK_W-1:0]     RST_PLANE2 = 8'd16;
  localparam logic [TICK_W-1:0]     RST_TICKS  = 8'd1;

  localparam logic [CELL_W-1:0] LEVEL_MAX  = 2'd3;
  localparam logic [1:0]        LAST_PLANE = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]  rows;
    logic [CNT_W-1:0]  cols;
    logic [TICK_W-1:0] dur0;
    logic [TICK_W-1:0] dur1;
    logic [TICK_W-1:0] dur2;
  } cfg_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              clear;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [CELL_W-1:0] level;
  } cell_ctl_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [IDX_W-1:0] row;
    logic [1:0]       plane;
  } plane_ctl_t;

  typedef struct packed {
    logic                 load;
    logic                 is_scan;
    logic                 level_ok;
    logic [ROW_SEL_W-1:0] row_sel;
  } resp_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_WR_MOD   = 7'b0000010,
    S_READ_OUT = 7'b0000100,
    S_TICK_OUT = 7'b0001000,
    S_REN_RD   = 7'b0010000,
    S_REN_WR   = 7'b0100000,
    S_SPARE    = 7'b1000000
  } state_t;

endpackage

@@ hw/rtl/lgs_cell_store.sv @@
// ----------------------------------------------------------------------------
// lgs_cell_store
// cell level memory, one matrix row per entry, with row valid bits
// ----------------------------------------------------------------------------
module lgs_cell_store #(
  parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lgs_pkg::cell_ctl_t                   ctl,
  output logic [lgs_pkg::CELL_W-1:0]           rd_level,
  output logic [lgs_pkg::CELL_W*MAX_COLUMNS-1:0] row_data
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = $clog2(MAX_COLUMNS);
  localparam int WORD_W = lgs_pkg::CELL_W * MAX_COLUMNS;

  logic [WORD_W-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] vld_r;
  logic [WORD_W-1:0] rdata_r;
  logic              rvld_r;
  logic [COL_AW-1:0] col_r;
  logic [ROW_AW-1:0] row_idx;
  logic [COL_AW-1:0] col_idx;
  logic [WORD_W-1:0] merged;

  assign row_idx  = ROW_AW'(ctl.row);
  assign col_idx  = COL_AW'(ctl.col);
  assign row_data = rvld_r ? rdata_r : '0;
  assign rd_level = row_data[{col_r, 1'b0} +: lgs_pkg::CELL_W];

  always_comb begin
    merged = row_data;
    merged[{col_idx, 1'b0} +: lgs_pkg::CELL_W] = ctl.level;
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[row_idx] <= merged;
    end
    if (ctl.rd) begin
      rdata_r <= mem[row_idx];
      col_r   <= col_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        vld_r <= '0;
      end else if (ctl.wr) begin
        vld_r[row_idx] <= 1'b1;
      end
      if (ctl.rd) begin
        rvld_r <= vld_r[row_idx];
      end
    end
  end

endmodule

@@ hw/rtl/lgs_plane_store.sv @@
// ----------------------------------------------------------------------------
// lgs_plane_store
// bit plane memory, three planes of one matrix row per entry
// ----------------------------------------------------------------------------
module lgs_plane_store #(
  parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lgs_pkg::plane_ctl_t                    ctl,
  input  logic [lgs_pkg::CNT_W-1:0]              cols,
  input  logic [lgs_pkg::CELL_W*MAX_COLUMNS-1:0] row_data,
  output logic [lgs_pkg::COL_BITS_W-1:0]         column_bits
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WORD_W = lgs_pkg::PLANES * MAX_COLUMNS;

  logic [WORD_W-1:0]   mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] vld_r;
  logic [WORD_W-1:0]   rdata_r;
  logic                rvld_r;
  logic [1:0]          plane_r;
  logic [ROW_AW-1:0]   row_idx;
  logic [WORD_W-1:0]   planes;
  logic [MAX_COLUMNS-1:0] sel_bits;

  assign row_idx = ROW_AW'(ctl.row);

  always_comb begin
    logic [lgs_pkg::CELL_W-1:0] lv;
    logic                       on;
    planes = '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      lv = row_data[c*lgs_pkg::CELL_W +: lgs_pkg::CELL_W];
      on = (lgs_pkg::CNT_W'(c) < cols);
      planes[c]                 = on && (lv != 2'd0);
      planes[MAX_COLUMNS + c]   = on && lv[1];
      planes[2*MAX_COLUMNS + c] = on && (lv == lgs_pkg::LEVEL_MAX);
    end
  end

  assign sel_bits    = rdata_r[plane_r*MAX_COLUMNS +: MAX_COLUMNS];
  assign column_bits = rvld_r ? lgs_pkg::COL_BITS_W'(sel_bits) : '0;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[row_idx] <= planes;
    end
    if (ctl.rd) begin
      rdata_r <= mem[row_idx];
      plane_r <= ctl.plane;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld_r[row_idx] <= 1'b1;
      end
      if (ctl.rd) begin
        rvld_r <= vld_r[row_idx];
      end
    end
  end

endmodule

@@ hw/rtl/lgs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lgs_ctrl
// command sequencer and scan position counters
// ----------------------------------------------------------------------------
module lgs_ctrl #(
  parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lgs_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lgs_pkg::KIND_W-1:0]     in_kind,
  input  logic [lgs_pkg::ROW_W-1:0]      in_row,
  input  logic [lgs_pkg::COLUMN_W-1:0]   in_column,
  input  logic [lgs_pkg::LEVEL_W-1:0]    in_level,
  input  logic                           out_free,
  output lgs_pkg::cell_ctl_t             cell_ctl,
  output lgs_pkg::plane_ctl_t            plane_ctl,
  output lgs_pkg::resp_t                 resp
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  lgs_pkg::state_t state_r, state_nxt;
  logic [lgs_pkg::IDX_W-1:0]     row_r, row_nxt;
  logic [lgs_pkg::IDX_W-1:0]     col_r, col_nxt;
  logic [lgs_pkg::CELL_W-1:0]    level_r, level_nxt;
  logic                          ok_r, ok_nxt;
  logic [lgs_pkg::ROW_SEL_W-1:0] row_sel_r, row_sel_nxt;
  logic [ROW_AW-1:0]             ren_row_r, ren_row_nxt;
  logic [ROW_AW-1:0]             scan_row_r, scan_row_nxt;
  logic [1:0]                    scan_plane_r, scan_plane_nxt;
  logic [lgs_pkg::TICK_W-1:0]    ticks_r, ticks_nxt;

  logic                          in_bounds;
  logic [lgs_pkg::CELL_W-1:0]    level_sat;
  logic [lgs_pkg::CNT_W-1:0]     scan_inc;
  logic [1:0]                    plane_inc;
  logic [lgs_pkg::TICK_W-1:0]    dur_next;

  assign in_stall  = (state_r != lgs_pkg::S_IDLE);
  assign in_bounds = (lgs_pkg::CNT_W'(in_row) < cfg.rows) &&
                     (lgs_pkg::CNT_W'(in_column) < cfg.cols);
  assign level_sat = (in_level > lgs_pkg::LEVEL_W'(lgs_pkg::LEVEL_MAX)) ?
                     lgs_pkg::LEVEL_MAX : in_level[lgs_pkg::CELL_W-1:0];
  assign scan_inc  = lgs_pkg::CNT_W'(scan_row_r) + lgs_pkg::CNT_W'(1);
  assign plane_inc = (scan_plane_r == lgs_pkg::LAST_PLANE) ? 2'd0 : scan_plane_r + 2'd1;

  always_comb begin
    case (plane_inc)
      2'd0:    dur_next = cfg.dur0;
      2'd1:    dur_next = cfg.dur1;
      default: dur_next = cfg.dur2;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    level_nxt      = level_r;
    ok_nxt         = ok_r;
    row_sel_nxt    = row_sel_r;
    ren_row_nxt    = ren_row_r;
    scan_row_nxt   = scan_row_r;
    scan_plane_nxt = scan_plane_r;
    ticks_nxt      = ticks_r;
    cell_ctl       = '0;
    plane_ctl      = '0;
    resp           = '0;
    case (state_r)
      lgs_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            lgs_pkg::KIND_WRITE: begin
              if (in_bounds) begin
                cell_ctl.rd  = 1'b1;
                cell_ctl.row = lgs_pkg::IDX_W'(in_row);
                cell_ctl.col = in_column;
                row_nxt      = lgs_pkg::IDX_W'(in_row);
                col_nxt      = in_column;
                level_nxt    = level_sat;
                state_nxt    = lgs_pkg::S_WR_MOD;
              end
            end
            lgs_pkg::KIND_READ: begin
              cell_ctl.rd  = 1'b1;
              cell_ctl.row = lgs_pkg::IDX_W'(in_row);
              cell_ctl.col = in_column;
              ok_nxt       = in_bounds;
              state_nxt    = lgs_pkg::S_READ_OUT;
            end
            lgs_pkg::KIND_CLEAR: begin
              cell_ctl.clear = 1'b1;
            end
            lgs_pkg::KIND_RENDER: begin
              if (cfg.rows != '0) begin
                ren_row_nxt = '0;
                state_nxt   = lgs_pkg::S_REN_RD;
              end
            end
            lgs_pkg::KIND_TICK: begin
              plane_ctl.rd    = 1'b1;
              plane_ctl.row   = lgs_pkg::IDX_W'(scan_row_r);
              plane_ctl.plane = scan_plane_r;
              row_sel_nxt     = (lgs_pkg::CNT_W'(scan_row_r) <
                                 lgs_pkg::CNT_W'(lgs_pkg::ROW_SEL_W)) ?
                                (lgs_pkg::ROW_SEL_W'(1) << scan_row_r) : '0;
              if (ticks_r > lgs_pkg::TICK_W'(1)) begin
                ticks_nxt = ticks_r - lgs_pkg::TICK_W'(1);
              end else begin
                scan_plane_nxt = plane_inc;
                ticks_nxt      = dur_next;
                if (scan_plane_r == lgs_pkg::LAST_PLANE) begin
                  if (scan_inc >= cfg.rows || scan_inc >= lgs_pkg::CNT_W'(MAX_ROWS)) begin
                    scan_row_nxt = '0;
                  end else begin
                    scan_row_nxt = ROW_AW'(scan_inc);
                  end
                end
              end
              state_nxt = lgs_pkg::S_TICK_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      lgs_pkg::S_WR_MOD: begin
        cell_ctl.wr    = 1'b1;
        cell_ctl.row   = row_r;
        cell_ctl.col   = col_r;
        cell_ctl.level = level_r;
        state_nxt      = lgs_pkg::S_IDLE;
      end
      lgs_pkg::S_READ_OUT: begin
        if (out_free) begin
          resp.load     = 1'b1;
          resp.level_ok = ok_r;
          state_nxt     = lgs_pkg::S_IDLE;
        end
      end
      lgs_pkg::S_TICK_OUT: begin
        if (out_free) begin
          resp.load    = 1'b1;
          resp.is_scan = 1'b1;
          resp.row_sel = row_sel_r;
          state_nxt    = lgs_pkg::S_IDLE;
        end
      end
      lgs_pkg::S_REN_RD: begin
        cell_ctl.rd  = 1'b1;
        cell_ctl.row = lgs_pkg::IDX_W'(ren_row_r);
        state_nxt    = lgs_pkg::S_REN_WR;
      end
      lgs_pkg::S_REN_WR: begin
        plane_ctl.wr  = 1'b1;
        plane_ctl.row = lgs_pkg::IDX_W'(ren_row_r);
        if (lgs_pkg::CNT_W'(ren_row_r) + lgs_pkg::CNT_W'(1) >= cfg.rows) begin
          state_nxt = lgs_pkg::S_IDLE;
        end else begin
          ren_row_nxt = ren_row_r + ROW_AW'(1);
          state_nxt   = lgs_pkg::S_REN_RD;
        end
      end
      default: begin
        state_nxt = lgs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lgs_pkg::S_IDLE;
      ren_row_r    <= '0;
      scan_row_r   <= '0;
      scan_plane_r <= '0;
      ticks_r      <= lgs_pkg::RST_TICKS;
    end else begin
      state_r      <= state_nxt;
      ren_row_r    <= ren_row_nxt;
      scan_row_r   <= scan_row_nxt;
      scan_plane_r <= scan_plane_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    level_r   <= level_nxt;
    ok_r      <= ok_nxt;
    row_sel_r <= row_sel_nxt;
  end

endmodule

@@ hw/rtl/led_matrix_grayscale_scanner_top.sv @@
// ----------------------------------------------------------------------------
// led_matrix_grayscale_scanner_top
// frame buffer and bit plane row scanner for a four level led matrix
// ----------------------------------------------------------------------------
//  channel  handshake          word
//  in_      in_valid/in_stall   kind, row, column, level
//  out_     out_valid/out_stall is_scan, read_level, row_select, column_bits
//  cfg_     cfg_valid/cfg_ready index, wdata (always ready)
//
//  write: row read, then merge and write back; an out of bounds write is dropped
//  read and tick: memory read, then a wait for the output register to free up
//  clear and unknown kinds: handled in idle, render: a read and a write per row in use
//  reset clears row valid bits at once, no clearing pass
//  one command in flight; in_stall is high while it works, out_stall only
//  delays the handover of a finished word
// ----------------------------------------------------------------------------
module led_matrix_grayscale_scanner_top #(
  parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lgs_pkg::KIND_W-1:0]         in_kind,
  input  logic [lgs_pkg::ROW_W-1:0]          in_row,
  input  logic [lgs_pkg::COLUMN_W-1:0]       in_column,
  input  logic [lgs_pkg::LEVEL_W-1:0]        in_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_is_scan,
  output logic [lgs_pkg::CELL_W-1:0]         out_read_level,
  output logic [lgs_pkg::ROW_SEL_W-1:0]      out_row_select,
  output logic [lgs_pkg::COL_BITS_W-1:0]     out_column_bits,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lgs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [lgs_pkg::ROWS_REG_W-1:0] rows_in_use_r;
  logic [lgs_pkg::COLS_REG_W-1:0] columns_in_use_r;
  logic [lgs_pkg::TICK_W-1:0]     plane0_ticks_r;
  logic [lgs_pkg::TICK_W-1:0]     plane1_ticks_r;
  logic [lgs_pkg::TICK_W-1:0]     plane2_ticks_r;

  logic                              out_valid_r;
  logic                              out_is_scan_r;
  logic [lgs_pkg::CELL_W-1:0]        out_read_level_r;
  logic [lgs_pkg::ROW_SEL_W-1:0]     out_row_select_r;
  logic [lgs_pkg::COL_BITS_W-1:0]    out_column_bits_r;

  lgs_pkg::cfg_t       cfg;
  lgs_pkg::cell_ctl_t  cell_ctl;
  lgs_pkg::plane_ctl_t plane_ctl;
  lgs_pkg::resp_t      resp;
  logic                out_free;
  logic [lgs_pkg::CELL_W-1:0]            cell_level;
  logic [lgs_pkg::CELL_W*MAX_COLUMNS-1:0] cell_row;
  logic [lgs_pkg::COL_BITS_W-1:0]        plane_bits;

  assign cfg_ready = 1'b1;

  assign cfg.rows = (lgs_pkg::CNT_W'(rows_in_use_r) > lgs_pkg::CNT_W'(MAX_ROWS)) ?
                    lgs_pkg::CNT_W'(MAX_ROWS) : lgs_pkg::CNT_W'(rows_in_use_r);
  assign cfg.cols = (lgs_pkg::CNT_W'(columns_in_use_r) > lgs_pkg::CNT_W'(MAX_COLUMNS)) ?
                    lgs_pkg::CNT_W'(MAX_COLUMNS) : lgs_pkg::CNT_W'(columns_in_use_r);
  assign cfg.dur0 = plane0_ticks_r;
  assign cfg.dur1 = plane1_ticks_r;
  assign cfg.dur2 = plane2_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r    <= lgs_pkg::RST_ROWS;
      columns_in_use_r <= lgs_pkg::RST_COLS;
      plane0_ticks_r   <= lgs_pkg::RST_PLANE0;
      plane1_ticks_r   <= lgs_pkg::RST_PLANE1;
      plane2_ticks_r   <= lgs_pkg::RST_PLANE2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lgs_pkg::CFG_ROWS:   rows_in_use_r    <= cfg_wdata[lgs_pkg::ROWS_REG_W-1:0];
        lgs_pkg::CFG_COLS:   columns_in_use_r <= cfg_wdata[lgs_pkg::COLS_REG_W-1:0];
        lgs_pkg::CFG_PLANE0: plane0_ticks_r   <= cfg_wdata;
        lgs_pkg::CFG_PLANE1: plane1_ticks_r   <= cfg_wdata;
        lgs_pkg::CFG_PLANE2: plane2_ticks_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  lgs_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_row    (in_row),
    .in_column (in_column),
    .in_level  (in_level),
    .out_free  (out_free),
    .cell_ctl  (cell_ctl),
    .plane_ctl (plane_ctl),
    .resp      (resp)
  );

  lgs_cell_store #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_cell_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cell_ctl),
    .rd_level (cell_level),
    .row_data (cell_row)
  );

  lgs_plane_store #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_plane_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (plane_ctl),
    .cols        (cfg.cols),
    .row_data    (cell_row),
    .column_bits (plane_bits)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.load) begin
      out_is_scan_r     <= resp.is_scan;
      out_read_level_r  <= resp.level_ok ? cell_level : '0;
      out_row_select_r  <= resp.row_sel;
      out_column_bits_r <= resp.is_scan ? plane_bits : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_scan     = out_is_scan_r;
  assign out_read_level  = out_read_level_r;
  assign out_row_select  = out_row_select_r;
  assign out_column_bits = out_column_bits_r;

endmodule
